/* hw/rtl/ptks_pkg.sv */
package ptks_pkg;

  localparam int CAPACITY     = 16;
  localparam int ENTITY_COUNT = 1024;
  localparam int PRIO_W       = 16;

  localparam int ENT_W   = $clog2(ENTITY_COUNT);
  localparam int CNT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HELD_W  = $clog2(CAPACITY + 1);
  localparam int LIMIT_W = 5;
  localparam int CMP_W   = 8;
  localparam int TDATA_W = ((ENT_W + PRIO_W + 7) / 8) * 8;
  localparam int PAD_W   = TDATA_W - ENT_W - PRIO_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // one slot of the ring; done marks a slot already sent in the current frame
  typedef struct packed {
    logic                     done;
    logic [ENT_W-1:0]         ent;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // per-cell strobes
  typedef struct packed {
    logic shift;
    logic load;
    logic clr_done;
    logic set_done;
  } cell_ctl_t;

  // sequencer to ring
  typedef struct packed {
    logic                     shift;
    logic                     load_en;
    logic [CNT_W-1:0]         load_idx;
    logic [ENT_W-1:0]         load_ent;
    logic signed [PRIO_W-1:0] load_prio;
    logic                     clr_done;
    logic                     set_done;
    logic [CNT_W-1:0]         set_idx;
  } ring_ctl_t;

endpackage

/* hw/rtl/ptks_cell.sv */
module ptks_cell (
  input  logic                              clk,
  input  ptks_pkg::cell_ctl_t               ctl,
  input  ptks_pkg::entry_t                  shift_in,
  input  logic [ptks_pkg::ENT_W-1:0]        load_ent,
  input  logic signed [ptks_pkg::PRIO_W-1:0] load_prio,
  output ptks_pkg::entry_t                  q
);

  ptks_pkg::entry_t slot_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      slot_r <= shift_in;
    end else begin
      if (ctl.load) begin
        slot_r.ent  <= load_ent;
        slot_r.prio <= load_prio;
      end
      if (ctl.clr_done) begin
        slot_r.done <= 1'b0;
      end else if (ctl.set_done) begin
        slot_r.done <= 1'b1;
      end
    end
  end

  assign q = slot_r;

endmodule

/* hw/rtl/ptks_seq.sv */
module ptks_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_has_cand,
  input  logic [ptks_pkg::ENT_W-1:0]          in_ent,
  input  logic signed [ptks_pkg::PRIO_W-1:0]  in_prio,
  input  logic                                in_end,
  input  logic [ptks_pkg::LIMIT_W-1:0]        kept_limit,
  input  ptks_pkg::entry_t                    head,
  output ptks_pkg::ring_ctl_t                 ring,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ptks_pkg::ENT_W-1:0]          out_ent,
  output logic signed [ptks_pkg::PRIO_W-1:0]  out_prio,
  output logic                                out_last,
  output logic                                out_empty
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MIN   = 6'b000010,
    S_REPL  = 6'b000100,
    S_EMIT  = 6'b001000,
    S_ESCAN = 6'b010000,
    S_PUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [ptks_pkg::HELD_W-1:0]         held_r;
  logic [ptks_pkg::HELD_W-1:0]         left_r;
  logic [ptks_pkg::CNT_W-1:0]          cnt_r;
  logic [ptks_pkg::ENT_W-1:0]          cand_ent_r;
  logic signed [ptks_pkg::PRIO_W-1:0]  cand_prio_r;
  logic                                end_pend_r;
  logic [ptks_pkg::ENT_W-1:0]          best_ent_r;
  logic signed [ptks_pkg::PRIO_W-1:0]  best_prio_r;
  logic [ptks_pkg::CNT_W-1:0]          best_idx_r;
  logic                                found_r;
  logic                                empty_r;
  logic                                out_valid_r;
  logic [ptks_pkg::ENT_W-1:0]          out_ent_r;
  logic signed [ptks_pkg::PRIO_W-1:0]  out_prio_r;
  logic                                out_last_r;
  logic                                out_empty_r;

  logic                       in_fire;
  logic                       out_free;
  logic                       put_fire;
  logic                       step_held;
  logic                       cnt_last;
  logic                       room;
  logic                       last_pick;
  logic [ptks_pkg::CMP_W-1:0] lim8;
  logic [ptks_pkg::CMP_W-1:0] eff8;
  logic [ptks_pkg::CMP_W-1:0] held8;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign put_fire  = (state_r == S_PUT) && out_free;
  assign step_held = ptks_pkg::HELD_W'(cnt_r) < held_r;
  assign cnt_last  = (cnt_r == ptks_pkg::CNT_W'(ptks_pkg::CAPACITY - 1));
  assign last_pick = empty_r || (left_r == ptks_pkg::HELD_W'(1));

  // zero or anything past capacity means full capacity
  assign lim8  = ptks_pkg::CMP_W'(kept_limit);
  assign eff8  = (lim8 == '0 || lim8 > ptks_pkg::CMP_W'(ptks_pkg::CAPACITY)) ?
                 ptks_pkg::CMP_W'(ptks_pkg::CAPACITY) : lim8;
  assign held8 = ptks_pkg::CMP_W'(held_r);
  assign room  = held8 < eff8;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_has_cand && !room) begin
            state_nxt = S_MIN;
          end else if (in_end) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_MIN:   if (cnt_last) state_nxt = S_REPL;
      S_REPL:  state_nxt = end_pend_r ? S_EMIT : S_IDLE;
      S_EMIT:  state_nxt = (held_r == '0) ? S_PUT : S_ESCAN;
      S_ESCAN: if (cnt_last) state_nxt = S_PUT;
      S_PUT: begin
        if (out_free) begin
          state_nxt = last_pick ? S_IDLE : S_ESCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ring           = '0;
    ring.shift     = (state_r == S_MIN) || (state_r == S_ESCAN);
    ring.clr_done  = (state_r == S_EMIT);
    ring.set_done  = put_fire && !empty_r;
    ring.set_idx   = best_idx_r;
    ring.load_idx  = best_idx_r;
    ring.load_ent  = cand_ent_r;
    ring.load_prio = cand_prio_r;
    if (state_r == S_IDLE) begin
      ring.load_en   = in_fire && in_has_cand && room;
      ring.load_idx  = held_r[ptks_pkg::CNT_W-1:0];
      ring.load_ent  = in_ent;
      ring.load_prio = in_prio;
    end else if (state_r == S_REPL) begin
      ring.load_en = cand_prio_r > best_prio_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_IDLE && in_fire) begin
        cand_ent_r  <= in_ent;
        cand_prio_r <= in_prio;
        end_pend_r  <= in_end;
        cnt_r       <= '0;
        if (in_has_cand && room) begin
          held_r <= held_r + ptks_pkg::HELD_W'(1);
        end
      end

      // first minimum over held slots, slot t sits at the head on step t
      if (state_r == S_MIN) begin
        cnt_r <= cnt_last ? '0 : cnt_r + ptks_pkg::CNT_W'(1);
        if (step_held && (cnt_r == '0 || head.prio < best_prio_r)) begin
          best_prio_r <= head.prio;
          best_idx_r  <= cnt_r;
        end
      end

      if (state_r == S_EMIT) begin
        left_r  <= held_r;
        empty_r <= (held_r == '0);
        found_r <= 1'b0;
        cnt_r   <= '0;
      end

      // first maximum among slots not yet sent keeps ties in slot order
      if (state_r == S_ESCAN) begin
        cnt_r <= cnt_last ? '0 : cnt_r + ptks_pkg::CNT_W'(1);
        if (step_held && !head.done && (!found_r || head.prio > best_prio_r)) begin
          best_prio_r <= head.prio;
          best_ent_r  <= head.ent;
          best_idx_r  <= cnt_r;
          found_r     <= 1'b1;
        end
      end

      if (put_fire) begin
        out_valid_r <= 1'b1;
        left_r      <= left_r - ptks_pkg::HELD_W'(1);
        found_r     <= 1'b0;
        cnt_r       <= '0;
        if (last_pick) begin
          held_r <= '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_fire) begin
      out_ent_r   <= empty_r ? '0 : best_ent_r;
      out_prio_r  <= empty_r ? '0 : best_prio_r;
      out_last_r  <= last_pick;
      out_empty_r <= empty_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ent   = out_ent_r;
  assign out_prio  = out_prio_r;
  assign out_last  = out_last_r;
  assign out_empty = out_empty_r;

  a_held_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held8 <= ptks_pkg::CMP_W'(ptks_pkg::CAPACITY))
    else $error("held count above capacity");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (put_fire && last_pick) |=> (held_r == '0 && state_r == S_IDLE))
    else $error("store not emptied after final result");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ESCAN && cnt_last) |=> (state_r == S_PUT && cnt_r == '0))
    else $error("emit scan did not hand over");

  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (put_fire && !empty_r) |-> found_r)
    else $error("result sent without a chosen slot");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ESCAN || state_r == S_MIN) |-> !in_ready)
    else $error("input taken during a ring scan");

endmodule

/* hw/rtl/priority_top_k_selector_unit.sv */
// Keeps the top candidates of a frame in a ring of slot cells and emits them
// sorted by descending priority (ties in slot order) on frame end. A candidate
// that finds a free slot below the limit is loaded straight into it. Once the
// limit is reached, the ring rotates once past the head comparator to find the
// first minimum, then the slot is overwritten if the new priority is strictly
// higher. On frame end every result is chosen by one full rotation of the
// ring; a result not yet taken on out_tready holds back the next one. An empty
// frame gives one result flagged in out_tuser. Results sit in an output
// register, so the next input transaction is taken while the final result
// waits downstream.
// Register 0 (byte address 0): kept_limit, 0 or above capacity means all slots.
module priority_top_k_selector_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ptks_pkg::TDATA_W-1:0]         in_tdata,  // cand_ent, cand_prio, pad
  input  logic                                 in_tuser,  // has_candidate
  input  logic                                 in_tlast,  // frame_end

  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ptks_pkg::TDATA_W-1:0]         out_tdata, // kept_ent, kept_prio, pad
  output logic                                 out_tuser, // empty_frame
  output logic                                 out_tlast, // last_of_run

  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ptks_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [ptks_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [ptks_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  logic [ptks_pkg::LIMIT_W-1:0] kept_limit_r;
  logic                         cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[ptks_pkg::CFG_ADDR_W-1:2] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_limit_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      kept_limit_r <= cfg_pwdata[ptks_pkg::LIMIT_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? ptks_pkg::CFG_DATA_W'(kept_limit_r) : '0;

  ptks_pkg::entry_t    cell_q [ptks_pkg::CAPACITY];
  ptks_pkg::ring_ctl_t ring;

  // slot k lives in cell k when the ring is at rest; a shift moves every
  // slot one cell toward the head, which wraps around to the tail
  for (genvar k = 0; k < ptks_pkg::CAPACITY; k++) begin : g_cell
    ptks_pkg::cell_ctl_t ctl;
    assign ctl.shift    = ring.shift;
    assign ctl.load     = ring.load_en  && (ring.load_idx == ptks_pkg::CNT_W'(k));
    assign ctl.clr_done = ring.clr_done;
    assign ctl.set_done = ring.set_done && (ring.set_idx == ptks_pkg::CNT_W'(k));

    ptks_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .shift_in  (cell_q[(k + 1) % ptks_pkg::CAPACITY]),
      .load_ent  (ring.load_ent),
      .load_prio (ring.load_prio),
      .q         (cell_q[k])
    );
  end

  logic [ptks_pkg::ENT_W-1:0]         out_ent;
  logic signed [ptks_pkg::PRIO_W-1:0] out_prio;

  ptks_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_has_cand (in_tuser),
    .in_ent      (in_tdata[ptks_pkg::ENT_W-1:0]),
    .in_prio     (in_tdata[ptks_pkg::ENT_W +: ptks_pkg::PRIO_W]),
    .in_end      (in_tlast),
    .kept_limit  (kept_limit_r),
    .head        (cell_q[0]),
    .ring        (ring),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_ent     (out_ent),
    .out_prio    (out_prio),
    .out_last    (out_tlast),
    .out_empty   (out_tuser)
  );

  if (ptks_pkg::PAD_W > 0) begin : g_pad
    assign out_tdata = {{ptks_pkg::PAD_W{1'b0}}, out_prio, out_ent};
  end else begin : g_nopad
    assign out_tdata = {out_prio, out_ent};
  end

endmodule
